### hdl/id_allocator_with_dual_release_unit_assert.svh
// Assertion macros for the identifier allocator.
`ifndef ID_ALLOCATOR_WITH_DUAL_RELEASE_UNIT_ASSERT_SVH
`define ID_ALLOCATOR_WITH_DUAL_RELEASE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IDA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("identifier allocator check failed");
`define IDA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("identifier allocator invariant failed");
`else
`define IDA_ASSERT(label, prop)
`define IDA_ASSERT_ALWAYS(label, prop)
`endif
`endif

### hdl/ida_pkg.sv
// Shared constants and codes of the identifier allocator.
package ida_pkg;

  localparam int NUM_IDS = 1024;
  localparam int ID_W    = 10;
  localparam int ADDR_W  = $clog2(NUM_IDS);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int ST_W    = 2;

  localparam logic [ID_W-1:0] FIRST_ID_RESET = 10'd2;
  localparam logic [ST_W-1:0] ST_BOTH = 2'b11;
  localparam logic [ST_W-1:0] ST_FREE = 2'b00;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_UPDATE = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_EXHAUSTED = 2'd1,
    ERR_UNCLAIMED = 2'd2
  } err_t;

endpackage

### hdl/ida_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ida_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/id_allocator_with_dual_release_unit.sv
// Identifier allocator: a request is taken on the input channel, and in the next
// cycle the status memory and the free-stack memory deliver their registered
// read data; the block then modifies state, writes it back and loads the
// result register, waiting while the result register stays full because the
// output side stalls; the next request may be taken while the result waits.
// After reset the status memory is swept to zero, one entry per cycle, over all
// NUM_IDS (1024) entries before the first request is taken; writes to first_id
// are taken at any time.
`include "id_allocator_with_dual_release_unit_assert.svh"

module id_allocator_with_dual_release_unit
  import ida_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [ID_W-1:0] cfg_wr_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      operation,
  input  logic [ID_W-1:0] target_id,
  input  logic [1:0]      keep_mask,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [ID_W-1:0] result_id,
  output logic            claimed,
  output logic            released,
  output logic [1:0]      error_code
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [ID_W-1:0]   first_id;
  logic [CNT_W-1:0]  next_fresh, next_fresh_next;
  logic [CNT_W-1:0]  stack_count, stack_count_next;
  logic [ADDR_W-1:0] clr_addr;

  logic [1:0]        op_q;
  logic [ID_W-1:0]   tid_q;
  logic [1:0]        keep_q;

  logic              st_we;
  logic [ADDR_W-1:0] st_wr_addr, st_rd_addr;
  logic [ST_W-1:0]   st_wr_data, st_rd_data;
  logic              stk_we;
  logic [ADDR_W-1:0] stk_wr_addr, stk_rd_addr;
  logic [ADDR_W-1:0] stk_rd_data;

  logic              accept, exec_done;
  logic              in_range, stack_hit, fresh_ok;
  logic [ST_W-1:0]   st_kept;
  logic [ADDR_W-1:0] alloc_id;
  logic [ID_W-1:0]   rid_c;
  logic              claimed_c, released_c;
  logic [1:0]        err_c;
  logic              ex_st_we;
  logic [ADDR_W-1:0] ex_st_addr;
  logic [ST_W-1:0]   ex_st_data;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign exec_done = (state == S_EXEC) && (!out_valid || out_ready);

  // Hold the read addresses while executing so a stalled result re-reads the same data.
  assign st_rd_addr  = (state == S_IDLE) ? ADDR_W'(target_id) : ADDR_W'(tid_q);
  assign stk_rd_addr = ADDR_W'(stack_count - CNT_W'(1));

  ida_ram #(.WIDTH(ST_W), .DEPTH(NUM_IDS)) u_status (
    .clk     (clk),
    .we      (st_we),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  ida_ram #(.WIDTH(ADDR_W), .DEPTH(NUM_IDS)) u_stack (
    .clk     (clk),
    .we      (stk_we),
    .wr_addr (stk_wr_addr),
    .wr_data (ADDR_W'(tid_q)),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  assign in_range  = 32'(tid_q) < NUM_IDS;
  assign stack_hit = (stack_count != '0) && (32'(stack_count) <= NUM_IDS);
  assign fresh_ok  = 32'(next_fresh) < NUM_IDS;
  assign st_kept   = st_rd_data & keep_q;

  always_comb begin
    rid_c            = tid_q;
    claimed_c        = 1'b0;
    released_c       = 1'b0;
    err_c            = ERR_OK;
    ex_st_we         = 1'b0;
    ex_st_addr       = ADDR_W'(tid_q);
    ex_st_data       = st_kept;
    stk_we           = 1'b0;
    stk_wr_addr      = ADDR_W'(stack_count);
    stack_count_next = stack_count;
    next_fresh_next  = next_fresh;
    alloc_id         = stk_rd_data;
    case (op_q)
      OP_ALLOC: begin
        if (stack_hit) begin
          alloc_id         = stk_rd_data;
          stack_count_next = stack_count - CNT_W'(1);
        end else begin
          alloc_id        = next_fresh[ADDR_W-1:0];
          next_fresh_next = next_fresh + CNT_W'(1);
        end
        if (stack_hit || fresh_ok) begin
          rid_c      = ID_W'(alloc_id);
          ex_st_we   = 1'b1;
          ex_st_addr = alloc_id;
          ex_st_data = ST_BOTH;
        end else begin
          rid_c           = '0;
          err_c           = ERR_EXHAUSTED;
          next_fresh_next = next_fresh;
        end
      end
      OP_UPDATE: begin
        if (!in_range || st_rd_data == ST_FREE) begin
          err_c = ERR_UNCLAIMED;
        end else begin
          ex_st_we = 1'b1;
          if (st_kept == ST_FREE) begin
            released_c = 1'b1;
            // Drop the push when the stack is already full.
            if (32'(stack_count) < NUM_IDS) begin
              stk_we           = exec_done;
              stack_count_next = stack_count + CNT_W'(1);
            end
          end
        end
      end
      default: begin
        claimed_c = in_range && (st_rd_data != ST_FREE);
      end
    endcase
  end

  always_comb begin
    if (state == S_CLEAR) begin
      st_we      = 1'b1;
      st_wr_addr = clr_addr;
      st_wr_data = ST_FREE;
    end else begin
      st_we      = exec_done && ex_st_we;
      st_wr_addr = ex_st_addr;
      st_wr_data = ex_st_data;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == ADDR_W'(NUM_IDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      first_id    <= FIRST_ID_RESET;
      next_fresh  <= CNT_W'(FIRST_ID_RESET);
      stack_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (exec_done) begin
        stack_count <= stack_count_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // A register write reloads the fresh counter.
      if (cfg_wr_en) begin
        first_id   <= cfg_wr_data;
        next_fresh <= CNT_W'(cfg_wr_data);
      end else if (exec_done) begin
        next_fresh <= next_fresh_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      tid_q  <= target_id;
      keep_q <= keep_mask;
    end
    if (exec_done) begin
      result_id  <= rid_c;
      claimed    <= claimed_c;
      released   <= released_c;
      error_code <= err_c;
    end
  end

  `IDA_ASSERT(a_out_from_exec, $rose(out_valid) |-> $past(state == S_EXEC))
  `IDA_ASSERT(a_release_clean, out_valid && released |-> error_code == ERR_OK && !claimed)
  `IDA_ASSERT(a_first_id_seen, $past(cfg_wr_en) |-> first_id == $past(cfg_wr_data))
  `IDA_ASSERT_ALWAYS(a_stack_bound, !rst |-> 32'(stack_count) <= NUM_IDS)

endmodule

### dv/id_allocator_with_dual_release_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the identifier allocator: it predicts each result and compares it.
module id_allocator_with_dual_release_unit_tb;
  import ida_pkg::*;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int MAX_IDLE     = 18;
  localparam int MAX_SHOWN    = 10;
  localparam int PHASE_ITEMS  = 330;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            claimed;
    logic            released;
    logic [1:0]      err;
  } id_result_t;

  class id_pool_scoreboard;
    logic [ST_W-1:0]  status [NUM_IDS];
    logic [ID_W-1:0]  free_ids [NUM_IDS];
    logic [CNT_W-1:0] free_count;
    logic [CNT_W-1:0] fresh_next;
    id_result_t       owed_results[$];
    int               mismatches;

    function new();
      foreach (status[i]) status[i] = ST_FREE;
      free_count = '0;
      fresh_next = {1'b0, FIRST_ID_RESET};
      mismatches = 0;
    endfunction

    // A first_id write also restarts the fresh counter.
    function void load_first_id(logic [ID_W-1:0] value);
      fresh_next = {1'b0, value};
    endfunction

    function void note_request(logic [1:0] op, logic [ID_W-1:0] tid, logic [1:0] keep);
      id_result_t      r;
      logic [ST_W-1:0] kept;
      r.id       = tid;
      r.claimed  = 1'b0;
      r.released = 1'b0;
      r.err      = ERR_OK;
      if (op == OP_ALLOC) begin
        // Reuse the most recently freed id before touching the counter.
        if (free_count != 0) begin
          free_count = free_count - 1'b1;
          r.id = free_ids[free_count];
          status[r.id] = ST_BOTH;
        end else if (fresh_next < NUM_IDS) begin
          r.id = fresh_next[ID_W-1:0];
          fresh_next = fresh_next + 1'b1;
          status[r.id] = ST_BOTH;
        end else begin
          r.id  = '0;
          r.err = ERR_EXHAUSTED;
        end
      end else if (op == OP_UPDATE) begin
        if (status[tid] == ST_FREE) begin
          r.err = ERR_UNCLAIMED;
        end else begin
          kept = status[tid] & keep;
          status[tid] = kept;
          if (kept == ST_FREE) begin
            r.released = 1'b1;
            // A full stack drops the push.
            if (free_count < NUM_IDS) begin
              free_ids[free_count] = tid;
              free_count = free_count + 1'b1;
            end
          end
        end
      end else begin
        r.claimed = (status[tid] != ST_FREE);
      end
      owed_results.push_back(r);
    endfunction

    function void check_response(id_result_t got);
      id_result_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result beat: id %0d claimed %0b released %0b err %0d",
                   got.id, got.claimed, got.released, got.err);
        return;
      end
      want = owed_results.pop_front();
      if (got.id !== want.id || got.claimed !== want.claimed ||
          got.released !== want.released || got.err !== want.err) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("result mismatch: expected id %0d claimed %0b released %0b err %0d, got id %0d claimed %0b released %0b err %0d",
                   want.id, want.claimed, want.released, want.err,
                   got.id, got.claimed, got.released, got.err);
      end
    endfunction

    // Find some claimed id, starting the scan at a random spot.
    function bit pick_claimed(output logic [ID_W-1:0] id);
      int start;
      start = $urandom_range(0, NUM_IDS - 1);
      id = '0;
      for (int k = 0; k < NUM_IDS; k++) begin
        id = ID_W'((start + k) % NUM_IDS);
        if (status[id] != ST_FREE) return 1'b1;
      end
      return 1'b0;
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            cfg_wr_en;
  logic [ID_W-1:0] cfg_wr_data;
  logic            in_valid;
  logic            in_ready;
  logic [1:0]      operation;
  logic [ID_W-1:0] target_id;
  logic [1:0]      keep_mask;
  logic            out_valid;
  logic            out_ready;
  logic [ID_W-1:0] result_id;
  logic            claimed;
  logic            released;
  logic [1:0]      error_code;

  id_pool_scoreboard id_pool;
  bit                send_calm;
  bit                take_calm;

  id_allocator_with_dual_release_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .target_id   (target_id),
    .keep_mask   (keep_mask),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_id   (result_id),
    .claimed     (claimed),
    .released    (released),
    .error_code  (error_code)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Enter and leave at a falling edge; valid stays up when the next beat follows at once.
  task automatic send_request(input logic [1:0] op, input logic [ID_W-1:0] tid,
                              input logic [1:0] keep);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    operation = op;
    target_id = tid;
    keep_mask = keep;
    do @(posedge clk); while (!in_ready);
    id_pool.note_request(op, tid, keep);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [1:0]      op;
    logic [ID_W-1:0] tid;
    logic [1:0]      keep;
    logic [ID_W-1:0] held;
    int              pick;
    pick = $urandom_range(0, 99);
    tid  = ID_W'($urandom_range(0, NUM_IDS - 1));
    keep = 2'($urandom_range(0, 3));
    // Mostly target live ids so updates walk the release path.
    if (pick < 35) begin
      op = OP_ALLOC;
    end else if (pick < 78) begin
      op = OP_UPDATE;
      if (pick < 70 && id_pool.pick_claimed(held)) tid = held;
    end else if (pick < 94) begin
      op = OP_QUERY;
      if (pick < 86 && id_pool.pick_claimed(held)) tid = held;
    end else begin
      op = OP_RESERVED;
    end
    send_request(op, tid, keep);
  endtask

  task automatic wait_pool_idle();
    in_valid = 1'b0;
    while (id_pool.owed_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_first_id(input logic [ID_W-1:0] value);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    id_pool.load_first_id(value);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic run_directed();
    // Only four fresh ids, so the counter runs dry quickly.
    write_first_id(10'd1020);
    send_request(OP_QUERY, 10'd0, 2'd0);
    send_request(OP_UPDATE, 10'd1023, 2'd3);
    send_request(OP_ALLOC, 10'd1023, 2'd3);
    send_request(OP_ALLOC, 10'd0, 2'd0);
    send_request(OP_ALLOC, 10'd512, 2'd1);
    send_request(OP_ALLOC, 10'd511, 2'd2);
    send_request(OP_ALLOC, 10'd0, 2'd0);
    send_request(OP_QUERY, 10'd1023, 2'd3);
    send_request(OP_UPDATE, 10'd1023, 2'd1);
    send_request(OP_UPDATE, 10'd1023, 2'd2);
    send_request(OP_QUERY, 10'd1023, 2'd0);
    send_request(OP_UPDATE, 10'd1023, 2'd3);
    send_request(OP_ALLOC, 10'd0, 2'd0);
    send_request(OP_UPDATE, 10'd1022, 2'd0);
    send_request(OP_UPDATE, 10'd1021, 2'd3);
    send_request(OP_RESERVED, 10'd1021, 2'd3);
    send_request(OP_ALLOC, 10'd0, 2'd0);
    send_request(OP_ALLOC, 10'd0, 2'd0);
    // Reload the counter onto an id that is still claimed.
    wait_pool_idle();
    write_first_id(10'd1021);
    send_request(OP_ALLOC, 10'd0, 2'd0);
    send_request(OP_UPDATE, 10'd1021, 2'd2);
    send_request(OP_UPDATE, 10'd1021, 2'd1);
    wait_pool_idle();
    write_first_id(10'd0);
    send_request(OP_ALLOC, 10'd0, 2'd0);
    send_request(OP_ALLOC, 10'd0, 2'd0);
    send_request(OP_QUERY, 10'd0, 2'd0);
  endtask

  // Result side: stall at random, check every beat at the rising edge.
  initial begin
    id_result_t got;
    int         stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
      stall = take_calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      got.id       = result_id;
      got.claimed  = claimed;
      got.released = released;
      got.err      = error_code;
      id_pool.check_response(got);
      @(negedge clk);
    end
  end

  initial begin
    logic [ID_W-1:0] phase_first [6];
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    operation   = OP_ALLOC;
    target_id   = '0;
    keep_mask   = '0;
    send_calm   = 1'b0;
    take_calm   = 1'b0;
    id_pool     = new();
    phase_first = '{10'd0, 10'd1023, 10'd1000, FIRST_ID_RESET, 10'd512,
                    ID_W'($urandom_range(0, NUM_IDS - 1))};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    foreach (phase_first[p]) begin
      wait_pool_idle();
      write_first_id(phase_first[p]);
      repeat (PHASE_ITEMS) send_random();
    end
    wait_pool_idle();

    if (id_pool.mismatches == 0 && id_pool.owed_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
